/* rtl/tlpc_pkg.sv */
// Shared types, widths and constants of the triangle lattice pixel classifier.
// Used by the channel interfaces and every module of the block; no dependencies.
`default_nettype none

package tlpc_pkg;

    // Screen geometry
    localparam int PIXELS_PER_CELL_X = 2;
    localparam int PIXELS_PER_CELL_Y = 4;
    localparam int SCREEN_SPAN       = 1024;

    // Field and register widths
    localparam int COORD_W   = 10;
    localparam int INV_W     = 18;
    localparam int BW_W      = 16;
    localparam int STRIPE_W  = 12;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 18;
    localparam int GLYPH_W   = 2;

    // Fixed-point formats
    localparam int SQRT3_Q16 = 113512;
    localparam int SQRT3_W   = 17;
    localparam int Q16       = 16;
    localparam int FRAC_BITS = 36;

    // Internal datapath widths
    localparam int DIFF_W = $clog2(SCREEN_SPAN) + 1;
    localparam int PX_W   = $clog2((SCREEN_SPAN - 1) * PIXELS_PER_CELL_X + 1) + 1;
    localparam int PY_W   = $clog2((SCREEN_SPAN - 1) * PIXELS_PER_CELL_Y + 1) + 1;
    localparam int SX_W   = PX_W + SQRT3_W;
    localparam int SY_W   = PY_W + Q16;
    localparam int A_W    = ((SX_W > SY_W) ? SX_W : SY_W) + 1;
    localparam int N_W    = FRAC_BITS + STRIPE_W;
    localparam int PROD_W = ((A_W + INV_W + 1) > N_W) ? (A_W + INV_W + 1) : N_W;
    localparam int D_W    = FRAC_BITS;

    // Glyph codes
    localparam logic [GLYPH_W-1:0] GLYPH_FLAT     = 2'd0;
    localparam logic [GLYPH_W-1:0] GLYPH_UP_RIGHT = 2'd1;
    localparam logic [GLYPH_W-1:0] GLYPH_UP_LEFT  = 2'd2;

    // Border widths above one half of a row mark every cell as edge
    localparam logic [BW_W-1:0] HALF_BW = 16'd32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INV_ROW_HEIGHT     = 3'd0,
        CFG_BORDER_WIDTH       = 3'd1,
        CFG_ORIGIN_COL         = 3'd2,
        CFG_ORIGIN_ROW         = 3'd3,
        CFG_CURSOR_ROW_STRIPE  = 3'd4,
        CFG_CURSOR_DIAG_STRIPE = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [INV_W-1:0]           inv_row_height;
        logic [BW_W-1:0]            border_width;
        logic [COORD_W-1:0]         origin_col;
        logic [COORD_W-1:0]         origin_row;
        logic signed [STRIPE_W-1:0] cursor_row_stripe;
        logic signed [STRIPE_W-1:0] cursor_diag_stripe;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        inv_row_height:     18'd60540,
        border_width:       16'd6554,
        origin_col:         10'd40,
        origin_row:         10'd11,
        cursor_row_stripe:  12'sd0,
        cursor_diag_stripe: 12'sd0
    };

    // Projections onto the flat, up-right and up-left line sets, Q.36, low bits kept
    typedef struct packed {
        logic [N_W-1:0] n1;
        logic [N_W-1:0] n2;
        logic [N_W-1:0] n3;
    } t_proj;

    typedef struct packed {
        logic                       edge_res;
        logic [GLYPH_W-1:0]         glyph;
        logic                       on_cursor;
        logic signed [STRIPE_W-1:0] row_stripe;
        logic signed [STRIPE_W-1:0] diag_stripe;
    } t_res;

endpackage

`default_nettype wire

/* rtl/tlpc_in_if.sv */
// Input channel of the classifier: one screen cell per word.
// Depends on tlpc_pkg for field widths.
`default_nettype none

interface tlpc_in_if;
    logic                         valid;
    logic                         ready;
    logic [tlpc_pkg::COORD_W-1:0] col;
    logic [tlpc_pkg::COORD_W-1:0] row;

    modport source (output valid, output col, output row, input ready);
    modport sink   (input valid, input col, input row, output ready);
endinterface

`default_nettype wire

/* rtl/tlpc_out_if.sv */
// Output channel of the classifier: one classification word per cell.
// Depends on tlpc_pkg for field widths.
`default_nettype none

interface tlpc_out_if;
    logic                                valid;
    logic                                ready;
    logic                                edge_res;
    logic [tlpc_pkg::GLYPH_W-1:0]        glyph;
    logic                                on_cursor;
    logic signed [tlpc_pkg::STRIPE_W-1:0] row_stripe;
    logic signed [tlpc_pkg::STRIPE_W-1:0] diag_stripe;

    modport source (output valid, output edge_res, output glyph, output on_cursor,
                    output row_stripe, output diag_stripe, input ready);
    modport sink   (input valid, input edge_res, input glyph, input on_cursor,
                    input row_stripe, input diag_stripe, output ready);
endinterface

`default_nettype wire

/* rtl/tlpc_project.sv */
// Front four pipeline stages: pixel offset, sqrt3 scaling, line-set sums and
// the multiply by the reciprocal row height. Depends on tlpc_pkg.
`default_nettype none

module tlpc_project (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire tlpc_pkg::t_cfg              i_cfg,
    input  wire                              i_valid,
    output logic                             o_ready,
    input  wire [tlpc_pkg::COORD_W-1:0]      i_col,
    input  wire [tlpc_pkg::COORD_W-1:0]      i_row,
    output logic                             o_valid,
    input  wire                              i_ready,
    output tlpc_pkg::t_proj                  o_proj
);

    localparam logic signed [tlpc_pkg::SQRT3_W:0] SQRT3_S =
        (tlpc_pkg::SQRT3_W + 1)'(tlpc_pkg::SQRT3_Q16);

    // Stage ready: a stage takes a word when empty or when its successor moves
    logic rdy1, rdy2, rdy3, rdy4;

    logic r_v1, r_v2, r_v3, r_v4;

    logic signed [tlpc_pkg::PX_W-1:0] r_px;
    logic signed [tlpc_pkg::PY_W-1:0] r_py;
    logic signed [tlpc_pkg::SX_W-1:0] r_sx;
    logic signed [tlpc_pkg::SY_W-1:0] r_sy;
    logic signed [tlpc_pkg::A_W-1:0]  r_a1, r_a2, r_a3;
    tlpc_pkg::t_proj                  r_proj;

    logic signed [tlpc_pkg::DIFF_W-1:0] w_dx, w_dy;
    logic signed [tlpc_pkg::PX_W-1:0]   n_px;
    logic signed [tlpc_pkg::PY_W-1:0]   n_py;
    logic signed [tlpc_pkg::SX_W-1:0]   n_sx;
    logic signed [tlpc_pkg::SY_W-1:0]   n_sy;
    logic signed [tlpc_pkg::A_W-1:0]    n_a1, n_a2, n_a3;
    logic signed [tlpc_pkg::INV_W:0]    w_inv;
    logic signed [tlpc_pkg::PROD_W-1:0] w_p1, w_p2, w_p3;
    tlpc_pkg::t_proj                    n_proj;

    assign rdy4    = !r_v4 || i_ready;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v4;
    assign o_proj  = r_proj;

    // Stage 1: cell offset from the origin, in pixels
    assign w_dx = $signed({1'b0, i_col}) - $signed({1'b0, i_cfg.origin_col});
    assign w_dy = $signed({1'b0, i_row}) - $signed({1'b0, i_cfg.origin_row});
    assign n_px = tlpc_pkg::PX_W'(w_dx * tlpc_pkg::PIXELS_PER_CELL_X);
    assign n_py = tlpc_pkg::PY_W'(w_dy * tlpc_pkg::PIXELS_PER_CELL_Y);

    // Stage 2: sqrt3 * px and py in Q.16
    assign n_sx = r_px * SQRT3_S;
    assign n_sy = $signed({r_py, {tlpc_pkg::Q16{1'b0}}});

    // Stage 3: line-set sums
    assign n_a1 = tlpc_pkg::A_W'(r_sy);
    assign n_a2 = tlpc_pkg::A_W'(r_sy) + tlpc_pkg::A_W'(r_sx);
    assign n_a3 = tlpc_pkg::A_W'(r_sy) - tlpc_pkg::A_W'(r_sx);

    // Stage 4: scale by the reciprocal row height into Q.36
    assign w_inv = $signed({1'b0, i_cfg.inv_row_height});
    assign w_p1  = r_a1 * w_inv;
    assign w_p2  = r_a2 * w_inv;
    assign w_p3  = r_a3 * w_inv;

    always_comb begin
        n_proj.n1 = w_p1[tlpc_pkg::N_W-1:0];
        n_proj.n2 = w_p2[tlpc_pkg::N_W-1:0];
        n_proj.n3 = w_p3[tlpc_pkg::N_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_px <= n_px;
            r_py <= n_py;
        end
        if (rdy2) begin
            r_sx <= n_sx;
            r_sy <= n_sy;
        end
        if (rdy3) begin
            r_a1 <= n_a1;
            r_a2 <= n_a2;
            r_a3 <= n_a3;
        end
        if (rdy4) begin
            r_proj <= n_proj;
        end
    end

endmodule

`default_nettype wire

/* rtl/tlpc_classify.sv */
// Back two pipeline stages: fold each projection to a line distance, then pick
// the nearest set, the edge flag and the cursor match. Depends on tlpc_pkg.
`default_nettype none

module tlpc_classify (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire tlpc_pkg::t_cfg i_cfg,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire tlpc_pkg::t_proj i_proj,
    output logic                o_valid,
    input  wire                 i_ready,
    output tlpc_pkg::t_res      o_res
);

    // Distance from a Q.36 value to the nearest integer, 0..0.5
    function automatic logic [tlpc_pkg::D_W-1:0] fold_dist(
        input logic [tlpc_pkg::N_W-1:0] n
    );
        logic [tlpc_pkg::D_W-1:0] t;
        t = n[tlpc_pkg::D_W-1:0];
        return t[tlpc_pkg::D_W-1] ? tlpc_pkg::D_W'(~t + tlpc_pkg::D_W'(1)) : t;
    endfunction

    logic rdy5, rdy6;
    logic r_v5, r_v6;

    logic [tlpc_pkg::D_W-1:0]          r_d1, r_d2, r_d3;
    logic signed [tlpc_pkg::STRIPE_W-1:0] r_s1, r_s2;
    tlpc_pkg::t_res                    r_res;

    logic [tlpc_pkg::D_W-1:0] w_d;
    logic [tlpc_pkg::D_W-1:0] w_bw;
    tlpc_pkg::t_res           n_res;

    assign rdy6    = !r_v6 || i_ready;
    assign rdy5    = !r_v5 || rdy6;
    assign o_ready = rdy5;
    assign o_valid = r_v6;
    assign o_res   = r_res;

    assign w_bw = {i_cfg.border_width, {(tlpc_pkg::D_W - tlpc_pkg::BW_W){1'b0}}};

    // Nearest set wins; ties keep the earlier set
    always_comb begin
        w_d         = r_d1;
        n_res.glyph = tlpc_pkg::GLYPH_FLAT;
        if (r_d2 < w_d) begin
            w_d         = r_d2;
            n_res.glyph = tlpc_pkg::GLYPH_UP_RIGHT;
        end
        if (r_d3 < w_d) begin
            w_d         = r_d3;
            n_res.glyph = tlpc_pkg::GLYPH_UP_LEFT;
        end
        n_res.edge_res    = (w_d < w_bw);
        n_res.on_cursor   = (r_s1 == i_cfg.cursor_row_stripe) &&
                            (r_s2 == i_cfg.cursor_diag_stripe);
        n_res.row_stripe  = r_s1;
        n_res.diag_stripe = r_s2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (rdy5) r_v5 <= i_valid;
            if (rdy6) r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy5) begin
            r_d1 <= fold_dist(i_proj.n1);
            r_d2 <= fold_dist(i_proj.n2);
            r_d3 <= fold_dist(i_proj.n3);
            r_s1 <= $signed(i_proj.n1[tlpc_pkg::N_W-1:tlpc_pkg::FRAC_BITS]);
            r_s2 <= $signed(i_proj.n2[tlpc_pkg::N_W-1:tlpc_pkg::FRAC_BITS]);
        end
        if (rdy6) begin
            r_res <= n_res;
        end
    end

endmodule

`default_nettype wire

/* rtl/triangle_lattice_pixel_classifier.sv */
// Throughput: one cell per cycle while o_cls.ready holds; six register stages,
// two of them multiplier stages (sqrt3 scaling, reciprocal row height), each
// holding under a stall.
// Reset: synchronous, active low; clears all stage valid bits and loads the
// configuration registers with their defaults.
// Top level: configuration registers, tlpc_project and tlpc_classify.
`default_nettype none

module triangle_lattice_pixel_classifier (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire [tlpc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire [tlpc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    tlpc_in_if.sink                          i_pix,
    tlpc_out_if.source                       o_cls
);

    tlpc_pkg::t_cfg  r_cfg;
    tlpc_pkg::t_cfg  n_cfg;

    logic            w_mid_valid;
    logic            w_mid_ready;
    tlpc_pkg::t_proj w_proj;
    tlpc_pkg::t_res  w_res;

    always_comb begin
        n_cfg = r_cfg;
        unique case (tlpc_pkg::t_cfg_idx'(i_cfg_idx))
            tlpc_pkg::CFG_INV_ROW_HEIGHT:
                n_cfg.inv_row_height = i_cfg_data[tlpc_pkg::INV_W-1:0];
            tlpc_pkg::CFG_BORDER_WIDTH:
                n_cfg.border_width = i_cfg_data[tlpc_pkg::BW_W-1:0];
            tlpc_pkg::CFG_ORIGIN_COL:
                n_cfg.origin_col = i_cfg_data[tlpc_pkg::COORD_W-1:0];
            tlpc_pkg::CFG_ORIGIN_ROW:
                n_cfg.origin_row = i_cfg_data[tlpc_pkg::COORD_W-1:0];
            tlpc_pkg::CFG_CURSOR_ROW_STRIPE:
                n_cfg.cursor_row_stripe = $signed(i_cfg_data[tlpc_pkg::STRIPE_W-1:0]);
            tlpc_pkg::CFG_CURSOR_DIAG_STRIPE:
                n_cfg.cursor_diag_stripe = $signed(i_cfg_data[tlpc_pkg::STRIPE_W-1:0]);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= tlpc_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            r_cfg <= n_cfg;
        end
    end

    tlpc_project u_project (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_pix.valid),
        .o_ready (i_pix.ready),
        .i_col   (i_pix.col),
        .i_row   (i_pix.row),
        .o_valid (w_mid_valid),
        .i_ready (w_mid_ready),
        .o_proj  (w_proj)
    );

    tlpc_classify u_classify (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (w_mid_valid),
        .o_ready (w_mid_ready),
        .i_proj  (w_proj),
        .o_valid (o_cls.valid),
        .i_ready (o_cls.ready),
        .o_res   (w_res)
    );

    assign o_cls.edge_res    = w_res.edge_res;
    assign o_cls.glyph       = w_res.glyph;
    assign o_cls.on_cursor   = w_res.on_cursor;
    assign o_cls.row_stripe  = w_res.row_stripe;
    assign o_cls.diag_stripe = w_res.diag_stripe;

    // Input backpressure only when every stage is full and the output stalls
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix.ready |-> (o_cls.valid && !o_cls.ready))
        else $error("input stalled while the pipeline has room");

    // A border wider than half a row covers every cell
    a_wide_border: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cls.valid && (r_cfg.border_width > tlpc_pkg::HALF_BW)) |-> o_cls.edge_res)
        else $error("cell not edge under a border wider than half a row");

    // Zero reciprocal collapses every projection to zero: flat wins the tie
    a_zero_inv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cls.valid && (r_cfg.inv_row_height == '0)) |->
            (o_cls.glyph == tlpc_pkg::GLYPH_FLAT && o_cls.row_stripe == '0))
        else $error("nonzero projection with zero reciprocal row height");

    // Cursor flag agrees with the reported stripes
    a_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cls.valid && o_cls.on_cursor) |->
            (o_cls.row_stripe == r_cfg.cursor_row_stripe &&
             o_cls.diag_stripe == r_cfg.cursor_diag_stripe))
        else $error("cursor flag set off the selected triangle");

endmodule

`default_nettype wire

/* tb/tb_triangle_lattice_pixel_classifier.sv */
// Self-checking bench for triangle_lattice_pixel_classifier: drives screen cells under
// bursty input and a stalling output, and compares every result word with a local model.
// Depends on tlpc_pkg, tlpc_in_if and tlpc_out_if from the RTL.

import tlpc_pkg::*;

typedef logic [FRAC_BITS:0] t_dist;

class cls_scoreboard;
    t_cfg cfg;
    t_res pending_cls[$];
    int   mismatches;

    function new();
        cfg        = CFG_RESET;
        mismatches = 0;
    endfunction

    function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_INV_ROW_HEIGHT:     cfg.inv_row_height     = data[INV_W-1:0];
            CFG_BORDER_WIDTH:       cfg.border_width       = data[BW_W-1:0];
            CFG_ORIGIN_COL:         cfg.origin_col         = data[COORD_W-1:0];
            CFG_ORIGIN_ROW:         cfg.origin_row         = data[COORD_W-1:0];
            CFG_CURSOR_ROW_STRIPE:  cfg.cursor_row_stripe  = data[STRIPE_W-1:0];
            CFG_CURSOR_DIAG_STRIPE: cfg.cursor_diag_stripe = data[STRIPE_W-1:0];
            default: ;
        endcase
    endfunction

    // Fold the fraction of a Q.36 projection to its distance from the nearest line
    function t_dist line_dist(logic [63:0] v);
        t_dist t;
        t = {1'b0, v[FRAC_BITS-1:0]};
        if (t < (t_dist'(1) << (FRAC_BITS - 1)))
            return t;
        return (t_dist'(1) << FRAC_BITS) - t;
    endfunction

    function t_res classify(t_cfg k, logic [COORD_W-1:0] c, logic [COORD_W-1:0] r);
        longint px, py, sx, sy, inv, n1, n2, n3;
        logic [63:0] u1, u2;
        t_dist d, d2, d3, bw;
        t_res res;
        px  = (longint'(c) - longint'(k.origin_col)) * PIXELS_PER_CELL_X;
        py  = (longint'(r) - longint'(k.origin_row)) * PIXELS_PER_CELL_Y;
        inv = longint'(k.inv_row_height);
        sx  = longint'(SQRT3_Q16) * px;
        sy  = py * (longint'(1) << Q16);
        n1  = sy * inv;
        n2  = (sx + sy) * inv;
        n3  = (sy - sx) * inv;
        u1  = n1;
        u2  = n2;
        // nearest line set wins; ties keep flat, then up-right
        d         = line_dist(u1);
        res.glyph = GLYPH_FLAT;
        d2        = line_dist(u2);
        d3        = line_dist(n3);
        if (d2 < d) begin
            d         = d2;
            res.glyph = GLYPH_UP_RIGHT;
        end
        if (d3 < d) begin
            d         = d3;
            res.glyph = GLYPH_UP_LEFT;
        end
        bw              = t_dist'(k.border_width) << (FRAC_BITS - BW_W);
        res.edge_res    = (d < bw);
        res.row_stripe  = u1[FRAC_BITS +: STRIPE_W];
        res.diag_stripe = u2[FRAC_BITS +: STRIPE_W];
        res.on_cursor   = (res.row_stripe == k.cursor_row_stripe) &&
                          (res.diag_stripe == k.cursor_diag_stripe);
        return res;
    endfunction

    function void note_cell(logic [COORD_W-1:0] c, logic [COORD_W-1:0] r);
        pending_cls.push_back(classify(cfg, c, r));
    endfunction

    function void check_result(t_res got);
        t_res want;
        if (pending_cls.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result word: edge=%0d glyph=%0d cur=%0d row=%0d diag=%0d",
                         got.edge_res, got.glyph, got.on_cursor, got.row_stripe,
                         got.diag_stripe);
            return;
        end
        want = pending_cls.pop_front();
        if (got.edge_res !== want.edge_res || got.glyph !== want.glyph ||
            got.on_cursor !== want.on_cursor || got.row_stripe !== want.row_stripe ||
            got.diag_stripe !== want.diag_stripe) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp edge=%0d glyph=%0d cur=%0d row=%0d diag=%0d / got edge=%0d glyph=%0d cur=%0d row=%0d diag=%0d",
                         want.edge_res, want.glyph, want.on_cursor, want.row_stripe,
                         want.diag_stripe, got.edge_res, got.glyph, got.on_cursor,
                         got.row_stripe, got.diag_stripe);
        end
    endfunction

    function int outstanding();
        return pending_cls.size();
    endfunction
endclass

module tb_triangle_lattice_pixel_classifier;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int RAND_PHASES     = 14;
    localparam int ITEMS_PER_PHASE = 125;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    tlpc_in_if  pix_if();
    tlpc_out_if cls_if();

    cls_scoreboard sb;
    int            cycles = 0;
    int            burst_left;
    logic [7:0]    stall_pat = 8'hFF;
    int            pat_age = 0;
    t_res          got_cls;

    always #5 i_clk = ~i_clk;

    triangle_lattice_pixel_classifier u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_pix      (pix_if),
        .o_cls      (cls_if)
    );

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_triangle_lattice_pixel_classifier NOT OK");
            $finish;
        end
    end

    // Predict each accepted cell word
    always @(posedge i_clk) begin
        if (i_rst_n && pix_if.valid && pix_if.ready)
            sb.note_cell(pix_if.col, pix_if.row);
    end

    // Check result words; stall on a rotating pattern that is redrawn now and then
    always @(posedge i_clk) begin
        if (i_rst_n && cls_if.valid && cls_if.ready) begin
            got_cls.edge_res    = cls_if.edge_res;
            got_cls.glyph       = cls_if.glyph;
            got_cls.on_cursor   = cls_if.on_cursor;
            got_cls.row_stripe  = cls_if.row_stripe;
            got_cls.diag_stripe = cls_if.diag_stripe;
            sb.check_result(got_cls);
        end
        pat_age++;
        if (pat_age >= 97) begin
            pat_age   = 0;
            stall_pat = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
        end else begin
            stall_pat = {stall_pat[0], stall_pat[7:1]};
        end
        cls_if.ready <= stall_pat[0];
    end

    task automatic send_cell(input logic [COORD_W-1:0] c, input logic [COORD_W-1:0] r);
        pix_if.valid <= 1'b1;
        pix_if.col   <= c;
        pix_if.row   <= r;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
        burst_left--;
        if (burst_left <= 0) begin
            pix_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 24);
        end
    endtask

    // Drop valid and wait until every predicted word has come back
    task automatic hold_off();
        pix_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    task automatic load_cfg(input t_cfg k);
        t_cfg_idx              order[6];
        logic [CFG_DATA_W-1:0] data;
        order = '{CFG_INV_ROW_HEIGHT, CFG_BORDER_WIDTH, CFG_ORIGIN_COL, CFG_ORIGIN_ROW,
                  CFG_CURSOR_ROW_STRIPE, CFG_CURSOR_DIAG_STRIPE};
        foreach (order[i]) begin
            case (order[i])
                CFG_INV_ROW_HEIGHT:     data = CFG_DATA_W'(k.inv_row_height);
                CFG_BORDER_WIDTH:       data = CFG_DATA_W'(k.border_width);
                CFG_ORIGIN_COL:         data = CFG_DATA_W'(k.origin_col);
                CFG_ORIGIN_ROW:         data = CFG_DATA_W'(k.origin_row);
                CFG_CURSOR_ROW_STRIPE:  data = {6'd0, k.cursor_row_stripe};
                default:                data = {6'd0, k.cursor_diag_stripe};
            endcase
            cfg_we   <= 1'b1;
            cfg_idx  <= order[i];
            cfg_data <= data;
            @(posedge i_clk);
            sb.write_reg(order[i], data);
        end
        cfg_we <= 1'b0;
    endtask

    initial begin
        t_cfg               k;
        t_res               anchor_res;
        logic [COORD_W-1:0] ac, ar, c, r;
        int                 pick;

        sb           = new();
        pix_if.valid = 1'b0;
        pix_if.col   = '0;
        pix_if.row   = '0;
        cls_if.ready = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = CFG_INV_ROW_HEIGHT;
        cfg_data     = '0;
        i_rst_n      = 1'b0;
        burst_left   = $urandom_range(1, 24);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: corners, origin cell and its neighbors
        send_cell(10'd0, 10'd0);
        send_cell(10'd1023, 10'd1023);
        send_cell(10'd0, 10'd1023);
        send_cell(10'd1023, 10'd0);
        send_cell(10'd40, 10'd11);
        send_cell(10'd41, 10'd11);
        send_cell(10'd40, 10'd12);
        send_cell(10'd39, 10'd10);
        send_cell(10'd512, 10'd300);
        send_cell(10'd600, 10'd800);
        hold_off();

        // Zero reciprocal, with and without a border
        k                = CFG_RESET;
        k.inv_row_height = '0;
        k.border_width   = '0;
        load_cfg(k);
        send_cell(10'd0, 10'd0);
        send_cell(10'd1023, 10'd1023);
        send_cell(10'd40, 10'd11);
        hold_off();
        k.border_width = 16'd1;
        load_cfg(k);
        send_cell(10'd40, 10'd11);
        send_cell(10'd7, 10'd900);
        hold_off();

        // Largest reciprocal, wide border, origin and cursor at their extremes
        k.inv_row_height     = '1;
        k.border_width       = '1;
        k.origin_col         = '0;
        k.origin_row         = '0;
        k.cursor_row_stripe  = 12'sh800;
        k.cursor_diag_stripe = 12'sh7FF;
        load_cfg(k);
        send_cell(10'd1023, 10'd1023);
        send_cell(10'd0, 10'd0);
        send_cell(10'd1023, 10'd0);
        send_cell(10'd0, 10'd1023);
        hold_off();

        // Smallest reciprocal, border of exactly one half, far origin
        k.inv_row_height     = 18'd1;
        k.border_width       = HALF_BW;
        k.origin_col         = '1;
        k.origin_row         = '1;
        anchor_res           = sb.classify(k, 10'd0, 10'd0);
        k.cursor_row_stripe  = anchor_res.row_stripe;
        k.cursor_diag_stripe = anchor_res.diag_stripe;
        load_cfg(k);
        send_cell(10'd0, 10'd0);
        send_cell(10'd1023, 10'd1023);
        send_cell(10'd0, 10'd1023);
        send_cell(10'd511, 10'd511);
        hold_off();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            pick = $urandom_range(0, 15);
            if (pick == 0)
                k.inv_row_height = '0;
            else if (pick == 1)
                k.inv_row_height = 18'd1;
            else if (pick == 2)
                k.inv_row_height = '1;
            else if (pick < 8)
                k.inv_row_height = 18'($urandom_range(20000, 200000));
            else
                k.inv_row_height = 18'($urandom);
            pick = $urandom_range(0, 7);
            if (pick == 0)
                k.border_width = '0;
            else if (pick == 1)
                k.border_width = HALF_BW;
            else if (pick == 2)
                k.border_width = 16'($urandom);
            else
                k.border_width = 16'($urandom_range(0, 32768));
            k.origin_col = ($urandom_range(0, 7) == 0) ? {COORD_W{ph[0]}} : 10'($urandom);
            k.origin_row = ($urandom_range(0, 7) == 0) ? {COORD_W{ph[1]}} : 10'($urandom);
            // aim the cursor at a real triangle most of the time
            ac         = 10'($urandom);
            ar         = 10'($urandom);
            anchor_res = sb.classify(k, ac, ar);
            if ($urandom_range(0, 4) == 0) begin
                k.cursor_row_stripe  = 12'($urandom);
                k.cursor_diag_stripe = 12'($urandom);
            end else begin
                k.cursor_row_stripe  = anchor_res.row_stripe;
                k.cursor_diag_stripe = anchor_res.diag_stripe;
            end
            load_cfg(k);

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pick = $urandom_range(0, 19);
                if (pick < 9) begin
                    c = ac + 10'($urandom_range(0, 8)) - 10'd4;
                    r = ar + 10'($urandom_range(0, 8)) - 10'd4;
                end else if (pick == 9) begin
                    c = k.origin_col;
                    r = 10'($urandom);
                end else if (pick == 10) begin
                    c = 10'($urandom);
                    r = k.origin_row;
                end else begin
                    c = 10'($urandom);
                    r = 10'($urandom);
                end
                if ($urandom_range(0, 299) == 0)
                    hold_off();
                send_cell(c, r);
            end
            hold_off();
        end

        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("tb_triangle_lattice_pixel_classifier OK");
        else
            $display("tb_triangle_lattice_pixel_classifier NOT OK");
        $finish;
    end

endmodule
